### src/scfl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the size-class free-list allocator.
package scfl_pkg;

   typedef struct packed {
      logic        kind;
      logic [11:0] size;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [15:0] address_res;
      logic [1:0]  status;
   } rsp_type;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_SERVED    = 2'd0;
   localparam logic [1:0] STATUS_OVERSIZE  = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_EXEC,
      ST_CARVE,
      ST_POP
   } state_type;

endpackage

### src/size_class_free_list_allocator_core.sv
`timescale 1ns / 1ps
// Size-class free-list allocator: sequencer, shared adder and free-list stores.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------
//  request | start, busy, req_data    | taken when start is high, busy low
//  result  | rsp_strobe, rsp_data     | one-cycle strobe, one per request
//
// Free, oversize and exhausted requests pass ST_HEAD and ST_EXEC, a pop from a
// non-empty list ST_HEAD, ST_EXEC and ST_POP; the result strobe comes in the
// first cycle with busy low. A refill runs in ST_CARVE: one link write per
// node through the single write port of the link RAM, stepped by the adder.
// Reset (synchronous) empties every class list and rewinds the arena; the
// link RAM needs no clearing pass. The receiver cannot stall results.
module size_class_free_list_allocator_core #(
   parameter int NUM_CLASSES = 32,
   parameter int BLOCK_BYTES = 512,
   parameter int ARENA_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  scfl_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_strobe,
   output scfl_pkg::rsp_type rsp_data
);

   localparam int ARENA_WORDS = ARENA_BYTES / 4;
   localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
   localparam int NUM_BLOCKS  = ARENA_BYTES / BLOCK_BYTES;
   localparam int WORD_W      = $clog2(ARENA_WORDS);
   localparam int LINK_W      = WORD_W + 1;
   localparam int BLK_W       = $clog2(NUM_BLOCKS + 1);
   localparam int BASE_W      = $clog2(ARENA_BYTES + 1);
   localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int NW_W        = $clog2(NUM_CLASSES + 1);
   localparam int SUM_W       = (WORD_W + 1 > 12) ? WORD_W + 1 : 12;
   localparam int FW          = (WORD_W + 1 > 14) ? WORD_W + 1 : 14;
   localparam int BA_W        = (WORD_W + 2 > 16) ? WORD_W + 2 : 16;

   scfl_pkg::state_type state_ff, state_in;

   logic [BLK_W-1:0]       blk_cnt_ff, blk_cnt_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [NUM_CLASSES-1:0] head_vld_ff, head_vld_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   logic                   kind_ff, kind_in;
   logic                   over_ff, over_in;
   logic                   in_arena_ff, in_arena_in;
   logic [CLS_W-1:0]       cls_ff, cls_in;
   logic [NW_W-1:0]        nw_ff, nw_in;
   logic [WORD_W-1:0]      word_ff, word_in;
   logic [WORD_W-1:0]      cur_ff, cur_in;
   logic [SUM_W-1:0]       lim_ff, lim_in;
   scfl_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // request decode
   logic [12:0]            size_rnd;
   logic [10:0]            cls_num;

   // shared adder
   logic [SUM_W-1:0]       alu_a, alu_b, alu_sum;

   // store ports
   logic                   head_we;
   logic [WORD_W-1:0]      head_wdata, head_rd;
   logic                   link_we;
   logic [WORD_W-1:0]      link_waddr;
   logic [LINK_W-1:0]      link_wdata, link_rd;

   logic                   head_vld_rd;
   logic [WORD_W-1:0]      base_word;
   logic                   can_carve;
   logic [BA_W-1:0]        head_byte;

   scfl_ram #(
      .DEPTH (NUM_CLASSES),
      .WIDTH (WORD_W)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (cls_ff),
      .wr_data (head_wdata),
      .rd_addr (cls_ff),
      .rd_data (head_rd)
   );

   scfl_ram #(
      .DEPTH (ARENA_WORDS),
      .WIDTH (LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (head_rd),
      .rd_data (link_rd)
   );

   assign size_rnd    = {1'b0, req_data.size} + 13'd3;
   assign cls_num     = (size_rnd[12:2] == 11'd0) ? 11'd1 : size_rnd[12:2];
   assign head_vld_rd = head_vld_ff[cls_ff];
   assign base_word   = WORD_W'(base_ff >> 2);
   assign can_carve   = (blk_cnt_ff < BLK_W'(NUM_BLOCKS)) &&
                        (SUM_W'(nw_ff) <= SUM_W'(BLOCK_WORDS));
   assign head_byte   = BA_W'({head_rd, 2'b00});
   assign alu_sum     = alu_a + alu_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scfl_pkg::ST_IDLE;
         blk_cnt_ff    <= '0;
         base_ff       <= '0;
         head_vld_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         blk_cnt_ff    <= blk_cnt_in;
         base_ff       <= base_in;
         head_vld_ff   <= head_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      over_ff     <= over_in;
      in_arena_ff <= in_arena_in;
      cls_ff      <= cls_in;
      nw_ff       <= nw_in;
      word_ff     <= word_in;
      cur_ff      <= cur_in;
      lim_ff      <= lim_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      blk_cnt_in    = blk_cnt_ff;
      base_in       = base_ff;
      head_vld_in   = head_vld_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      kind_in       = kind_ff;
      over_in       = over_ff;
      in_arena_in   = in_arena_ff;
      cls_in        = cls_ff;
      nw_in         = nw_ff;
      word_in       = word_ff;
      cur_in        = cur_ff;
      lim_in        = lim_ff;
      alu_a         = SUM_W'(cur_ff);
      alu_b         = SUM_W'(nw_ff);
      head_we       = 1'b0;
      head_wdata    = head_rd;
      link_we       = 1'b0;
      link_waddr    = cur_ff;
      link_wdata    = {1'b0, head_rd};

      case (state_ff)
         scfl_pkg::ST_IDLE: begin
            if (start) begin
               kind_in     = req_data.kind;
               over_in     = cls_num > 11'(NUM_CLASSES);
               cls_in      = CLS_W'(cls_num - 11'd1);
               nw_in       = NW_W'(cls_num);
               in_arena_in = FW'(req_data.address[15:2]) < FW'(ARENA_WORDS);
               word_in     = WORD_W'(req_data.address[15:2]);
               state_in    = scfl_pkg::ST_HEAD;
            end
         end

         // wait for the head read of the selected class
         scfl_pkg::ST_HEAD: begin
            state_in = scfl_pkg::ST_EXEC;
         end

         scfl_pkg::ST_EXEC: begin
            alu_a = SUM_W'(base_word);
            alu_b = SUM_W'(BLOCK_WORDS) - SUM_W'(nw_ff);
            rsp_data_in.address_res = 16'd0;
            rsp_data_in.status      = scfl_pkg::STATUS_SERVED;
            if (over_ff) begin
               rsp_data_in.status = scfl_pkg::STATUS_OVERSIZE;
               rsp_strobe_in      = 1'b1;
               state_in           = scfl_pkg::ST_IDLE;
            end else if (kind_ff == scfl_pkg::KIND_FREE) begin
               // push the node on the head of its list
               if (in_arena_ff) begin
                  link_we             = 1'b1;
                  link_waddr          = word_ff;
                  link_wdata          = {head_vld_rd, head_rd};
                  head_we             = 1'b1;
                  head_wdata          = word_ff;
                  head_vld_in[cls_ff] = 1'b1;
               end
               rsp_strobe_in = 1'b1;
               state_in      = scfl_pkg::ST_IDLE;
            end else if (head_vld_rd) begin
               state_in = scfl_pkg::ST_POP;
            end else if (can_carve) begin
               // first node of the new block becomes the head
               head_we             = 1'b1;
               head_wdata          = base_word;
               head_vld_in[cls_ff] = 1'b1;
               cur_in              = base_word;
               lim_in              = alu_sum;
               blk_cnt_in          = blk_cnt_ff + BLK_W'(1);
               base_in             = base_ff + BASE_W'(BLOCK_BYTES);
               state_in            = scfl_pkg::ST_CARVE;
            end else begin
               rsp_data_in.status = scfl_pkg::STATUS_EXHAUSTED;
               rsp_strobe_in      = 1'b1;
               state_in           = scfl_pkg::ST_IDLE;
            end
         end

         // link one node to the next, close the list on the last node
         scfl_pkg::ST_CARVE: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            if (alu_sum <= lim_ff) begin
               link_wdata = {1'b1, WORD_W'(alu_sum)};
               cur_in     = WORD_W'(alu_sum);
            end else begin
               link_wdata = '0;
               state_in   = scfl_pkg::ST_HEAD;
            end
         end

         scfl_pkg::ST_POP: begin
            head_we                 = 1'b1;
            head_wdata              = link_rd[WORD_W-1:0];
            head_vld_in[cls_ff]     = link_rd[WORD_W];
            rsp_data_in.address_res = head_byte[15:0];
            rsp_data_in.status      = scfl_pkg::STATUS_SERVED;
            rsp_strobe_in           = 1'b1;
            state_in                = scfl_pkg::ST_IDLE;
         end

         default: begin
            state_in = scfl_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != scfl_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != scfl_pkg::STATUS_SERVED)
         |-> (rsp_data.address_res == 16'd0))
      else $error("failed request returned an address");

   a_blk_bound: assert property (@(posedge clock) disable iff (reset)
      blk_cnt_ff <= BLK_W'(NUM_BLOCKS))
      else $error("arena block counter overran");

endmodule

### src/scfl_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one registered read port.
module scfl_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the size-class free-list allocator core.
module tb;

   localparam int NUM_CLASSES    = 32;
   localparam int BLOCK_BYTES    = 512;
   localparam int ARENA_BYTES    = 65536;
   localparam int ARENA_WORDS    = ARENA_BYTES / 4;
   localparam int NUM_BLOCKS     = ARENA_BYTES / BLOCK_BYTES;
   localparam int RANDOM_ITEMS   = 540;
   localparam int QUIET_TAIL     = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HEAD_VALID     = 14;

   logic              clock;
   logic              reset;
   logic              start;
   scfl_pkg::req_type req_data;
   logic              busy;
   logic              rsp_strobe;
   scfl_pkg::rsp_type rsp_data;

   // predicted allocator state: bit 14 marks a valid link, bits 13:0 the word
   logic [14:0] class_head [NUM_CLASSES];
   logic [14:0] next_link [ARENA_WORDS];
   int unsigned blocks_used;

   scfl_pkg::rsp_type awaited_grants [$];
   scfl_pkg::rsp_type last_grant;
   int unsigned mismatches;
   int unsigned watchdog_count;
   int unsigned accepted_count;
   int unsigned served_allocs;
   int unsigned frees_taken;
   int unsigned oversize_count;
   int unsigned exhausted_count;
   int unsigned refill_count;

   logic [15:0] held_addr [$];
   logic [11:0] held_size [$];

   size_class_free_list_allocator_core #(
      .NUM_CLASSES(NUM_CLASSES),
      .BLOCK_BYTES(BLOCK_BYTES),
      .ARENA_BYTES(ARENA_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      $display("MISMATCH at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   // Carve the next arena block into nodes of the given class, linked in address order.
   function automatic bit carve_block(input int unsigned cls);
      int unsigned node_words;
      int unsigned count;
      int unsigned base;
      int unsigned w;
      int unsigned prev;
      logic [14:0] old_head;
      node_words = cls + 1;
      count = BLOCK_BYTES / (node_words * 4);
      prev = 0;
      if (blocks_used >= NUM_BLOCKS || count == 0)
         return 1'b0;
      base = blocks_used * (BLOCK_BYTES / 4);
      old_head = class_head[cls];
      for (int unsigned k = 0; k < count; k++) begin
         w = base + k * node_words;
         if (w >= ARENA_WORDS)
            break;
         if (k == 0)
            class_head[cls] = {1'b1, w[13:0]};
         else
            next_link[prev] = {1'b1, w[13:0]};
         prev = w;
      end
      next_link[prev] = old_head;
      blocks_used++;
      refill_count++;
      return 1'b1;
   endfunction

   function automatic scfl_pkg::rsp_type compute_grant(input scfl_pkg::req_type r);
      scfl_pkg::rsp_type g;
      int unsigned       cls_num;
      int unsigned       cls;
      int unsigned       w;
      g.address_res = '0;
      g.status = scfl_pkg::STATUS_SERVED;
      cls_num = (32'(r.size) + 3) >> 2;
      if (cls_num == 0)
         cls_num = 1;
      if (cls_num > NUM_CLASSES) begin
         g.status = scfl_pkg::STATUS_OVERSIZE;
      end else begin
         cls = cls_num - 1;
         if (r.kind == scfl_pkg::KIND_FREE) begin
            // low two address bits drop; the node goes on the head of its list
            w = 32'(r.address) >> 2;
            next_link[w] = class_head[cls];
            class_head[cls] = {1'b1, w[13:0]};
         end else if (!class_head[cls][HEAD_VALID] && !carve_block(cls)) begin
            g.status = scfl_pkg::STATUS_EXHAUSTED;
         end else begin
            w = 32'(class_head[cls][13:0]);
            class_head[cls] = next_link[w];
            g.address_res = 16'(w << 2);
         end
      end
      return g;
   endfunction

   // Check each result against the oldest prediction, then predict the request taken.
   always @(posedge clock) begin
      scfl_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (awaited_grants.size() == 0) begin
               report_mismatch("result with no request outstanding", 32'(rsp_data), 0);
            end else begin
               want = awaited_grants.pop_front();
               if (rsp_data.address_res !== want.address_res)
                  report_mismatch("address_res", 32'(rsp_data.address_res),
                                  32'(want.address_res));
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
         if (start && !busy) begin
            last_grant = compute_grant(req_data);
            awaited_grants = {awaited_grants, last_grant};
            accepted_count++;
            if (last_grant.status == scfl_pkg::STATUS_OVERSIZE)
               oversize_count++;
            else if (last_grant.status == scfl_pkg::STATUS_EXHAUSTED)
               exhausted_count++;
            else if (req_data.kind == scfl_pkg::KIND_FREE)
               frees_taken++;
            else
               served_allocs++;
         end
         if (rsp_strobe || (start && !busy))
            watchdog_count = 0;
         else
            watchdog_count++;
         if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("size_class_free_list_allocator_core verification failed");
            $finish;
         end
      end
   end

   // Called and returns at a falling edge; start stays high for a following request.
   task automatic send_request(input logic k, input logic [11:0] sz, input logic [15:0] ad);
      scfl_pkg::req_type r;
      r.kind = k;
      r.size = sz;
      r.address = ad;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!(start && !busy));
      @(negedge clock);
   endtask

   task automatic hold_off(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(negedge clock); while (awaited_grants.size() != 0);
   endtask

   task automatic test_directed();
      // size zero maps to the 4-byte class
      send_request(scfl_pkg::KIND_ALLOC, 12'd0,    16'hFFFF);
      send_request(scfl_pkg::KIND_ALLOC, 12'd1,    16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd4,    16'h1234);
      send_request(scfl_pkg::KIND_ALLOC, 12'd5,    16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd128,  16'h0000);  // largest class
      send_request(scfl_pkg::KIND_ALLOC, 12'd129,  16'h0000);  // just oversize
      send_request(scfl_pkg::KIND_ALLOC, 12'd4095, 16'hFFFF);
      // oversize free changes nothing
      send_request(scfl_pkg::KIND_FREE,  12'd4095, 16'hFFFF);
      send_request(scfl_pkg::KIND_FREE,  12'd3,    16'h0003);  // low address bits dropped
      send_request(scfl_pkg::KIND_ALLOC, 12'd2,    16'h0000);
      send_request(scfl_pkg::KIND_FREE,  12'd8,    16'h0010);  // wrong class for this node
      send_request(scfl_pkg::KIND_FREE,  12'd8,    16'h0010);  // and freed twice
      send_request(scfl_pkg::KIND_ALLOC, 12'd8,    16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd7,    16'h0000);
      send_request(scfl_pkg::KIND_FREE,  12'd128,  16'hFFFF);
      send_request(scfl_pkg::KIND_ALLOC, 12'd125,  16'h0000);
      send_request(scfl_pkg::KIND_FREE,  12'd0,    16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd124,  16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'h800,  16'h5555);
      send_request(scfl_pkg::KIND_FREE,  12'd96,   16'hAAA8);
      send_request(scfl_pkg::KIND_FREE,  12'd100,  16'h5557);
      send_request(scfl_pkg::KIND_ALLOC, 12'd100,  16'hAAAA);
      wait_for_drain();
   endtask

   task automatic test_random();
      int unsigned pick;
      int unsigned idx;
      logic [11:0] sz;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
            hold_off($urandom_range(1, 12));
         if (i == RANDOM_ITEMS / 2)
            wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            sz = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(129, 4095))
                                              : 12'($urandom_range(0, 128));
            send_request(scfl_pkg::KIND_ALLOC, sz, 16'($urandom));
            if (last_grant.status == scfl_pkg::STATUS_SERVED && held_addr.size() < 64) begin
               held_addr = {held_addr, last_grant.address_res};
               held_size = {held_size, sz};
            end
         end else if (pick < 82 && held_addr.size() > 0) begin
            // return a node that is out on loan
            idx = $urandom_range(0, held_addr.size() - 1);
            send_request(scfl_pkg::KIND_FREE, held_size[idx], held_addr[idx]);
            held_addr.delete(idx);
            held_size.delete(idx);
         end else begin
            sz = $urandom_range(0, 1) ? 12'($urandom_range(0, 140))
                                      : 12'($urandom_range(0, 4095));
            send_request(1'($urandom_range(0, 1)), sz, 16'($urandom));
         end
      end
   endtask

   task automatic test_exhaustion();
      int guard;
      int empty_cls;
      guard = 0;
      empty_cls = -1;
      // drain the largest class until the arena has no block left to carve
      while (!(blocks_used >= NUM_BLOCKS && !class_head[NUM_CLASSES - 1][HEAD_VALID])
             && guard < 900) begin
         send_request(scfl_pkg::KIND_ALLOC, 12'd128, 16'($urandom));
         guard++;
      end
      send_request(scfl_pkg::KIND_ALLOC, 12'd128, 16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd127, 16'hFFFF);
      for (int c = 0; c < NUM_CLASSES; c++)
         if (empty_cls < 0 && !class_head[c][HEAD_VALID])
            empty_cls = c;
      if (empty_cls >= 0)
         send_request(scfl_pkg::KIND_ALLOC, 12'((empty_cls + 1) * 4), 16'h0000);
      // a freed node is still served once the arena is spent
      send_request(scfl_pkg::KIND_FREE,  12'd128, 16'h1230);
      send_request(scfl_pkg::KIND_ALLOC, 12'd128, 16'h0000);
      send_request(scfl_pkg::KIND_ALLOC, 12'd128, 16'h0000);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      last_grant = '0;
      mismatches = 0;
      watchdog_count = 0;
      accepted_count = 0;
      served_allocs = 0;
      frees_taken = 0;
      oversize_count = 0;
      exhausted_count = 0;
      refill_count = 0;
      blocks_used = 0;
      for (int c = 0; c < NUM_CLASSES; c++)
         class_head[c] = '0;
      for (int w = 0; w < ARENA_WORDS; w++)
         next_link[w] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random();
      test_exhaustion();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("%0d requests: %0d allocations served, %0d frees, %0d oversize, %0d exhausted",
               accepted_count, served_allocs, frees_taken, oversize_count, exhausted_count);
      $display("%0d list refills carved %0d of %0d arena blocks",
               refill_count, blocks_used, NUM_BLOCKS);
      if (mismatches == 0) begin
         $display("size_class_free_list_allocator_core verification clean");
      end else begin
         $display("size_class_free_list_allocator_core verification failed");
      end
      $finish;
   end

endmodule
